// ===== hw/rtl/swrl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register indexes and constants of the sliding-window rate limiter.
package swrl_pkg;

	typedef struct packed {
		logic        func;
		logic [39:0] now_ms;
		logic [23:0] amount;
	} swrl_in_t;

	typedef struct packed {
		logic [15:0] wait_ms;
		logic        dropped_oldest;
	} swrl_out_t;

	typedef struct packed {
		logic [39:0] ts_ms;
		logic [23:0] amount;
	} swrl_entry_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_BYTES  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_MS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED_WAIT = 3'd4;

	localparam logic [1:0] MODE_BLOCKED = 2'd1;
	localparam logic [1:0] MODE_BYTES   = 2'd2;

	localparam logic [15:0] HISTORY_RST = 16'd5000;
	localparam logic [15:0] WINDOW_RST  = 16'd1000;
	localparam logic [15:0] BLOCKED_RST = 16'd60000;
	localparam logic [15:0] WAIT_MAX    = 16'hFFFF;

	// Ring read address source
	typedef enum logic [1:0] {
		RD_OLDEST,
		RD_OLDEST_NEXT,
		RD_NEWEST,
		RD_PTR_PREV
	} swrl_rd_sel_t;

	// Result register update
	typedef enum logic [1:0] {
		RES_HOLD,
		RES_ZERO,
		RES_BLOCKED,
		RES_WINDOW
	} swrl_res_op_t;

	typedef struct packed {
		logic         capture;
		logic         record;
		logic         pop;
		logic         rd_en;
		swrl_rd_sel_t rd_sel;
		logic         sum_start;
		logic         acc;
		logic         step;
		logic         hit;
		swrl_res_op_t res_op;
		logic         load_out;
	} swrl_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       disc_en;
		logic       count_nz;
		logic       count_gt1;
		logic       old;
		logic       reached;
		logic       last;
	} swrl_status_t;

endpackage

// ===== hw/rtl/sliding_window_rate_limiter_unit.sv =====
`timescale 1ns / 1ps
// Top level of the sliding-window rate limiter: controller plus datapath.
//
// Input transactions carry func, now_ms and amount. func 0 records a transfer
// in a ring of RING_DEPTH (timestamp, amount) entries; func 1 queries how many
// milliseconds to wait before more transfer is allowed. Every input transaction
// yields exactly one output transaction (wait_ms, dropped_oldest).
// Configuration is written through cfg_we/cfg_index/cfg_data, by the user only
// while no transaction is in work (the block does not enforce this); unknown
// indexes are ignored. A record passes through ST_REC, then ST_DONE, which loads
// the output register and raises out_valid. A query steps through ST_QRY to
// start, ST_DISC to discard D stale entries from the oldest end, ST_SEL to pick
// the answer, ST_SUM to sum S entries from the newest backward, ST_FIN to form
// the wait when the limit is reached and ST_DONE to load the output register.
// D + S never exceeds RING_DEPTH, as the sum covers only entries left by the
// discard; the single read port of the ring memory delivers one entry per cycle.
// One transaction is in work at a time; loading its result returns the block to
// ST_IDLE, which accepts again even while the output register holds that result.
// If the receiver stalls, the result holds and a finished transaction waits
// for the output register to free up. Reset empties the ring, restores the
// register defaults and drops any pending result; no clearing pass is needed.
module sliding_window_rate_limiter_unit #(
	parameter int RING_DEPTH = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  swrl_pkg::swrl_in_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output swrl_pkg::swrl_out_t             out_data,
	input  logic                            cfg_we,
	input  logic [swrl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swrl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import swrl_pkg::*;

	swrl_cmd_t    cmd;
	swrl_status_t st;

	swrl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_func   (in_data.func),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	swrl_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.st        (st),
		.out_data  (out_data)
	);

endmodule

// ===== hw/rtl/swrl_dp.sv =====
`timescale 1ns / 1ps
// Datapath: configuration registers, record ring memory, pointers, running sum and result.
module swrl_dp #(
	parameter int RING_DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [swrl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [swrl_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  swrl_pkg::swrl_in_t                  in_data,
	input  swrl_pkg::swrl_cmd_t                 cmd,
	output swrl_pkg::swrl_status_t              st,
	output swrl_pkg::swrl_out_t                 out_data
);
	import swrl_pkg::*;

	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam int CNT_W = $clog2(RING_DEPTH + 1);
	localparam int SUM_W = 24 + CNT_W;
	localparam int CMP_W = (SUM_W > 32) ? SUM_W : 32;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(RING_DEPTH);
	localparam logic [CNT_W:0]   DEPTH_X  = (CNT_W + 1)'(RING_DEPTH);

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
		return (i == '0) ? LAST_IDX : i - 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] base,
	                                             input logic [CNT_W-1:0] ofs);
		logic [CNT_W:0] s;
		s = (CNT_W + 1)'(base) + {1'b0, ofs};
		if (s >= DEPTH_X)
			s = s - DEPTH_X;
		return s[IDX_W-1:0];
	endfunction

	// configuration
	logic [1:0]  limit_mode_q;
	logic [31:0] limit_bytes_q;
	logic [15:0] history_q;
	logic [15:0] window_q;
	logic [15:0] blocked_q;

	// ring bookkeeping
	logic [IDX_W-1:0] oldest_q;
	logic [CNT_W-1:0] count_q;
	swrl_entry_t      ring_mem [RING_DEPTH];
	swrl_entry_t      rdata_q;

	// per-transaction working registers
	logic [39:0]      now_q;
	logic [23:0]      amount_in_q;
	logic [39:0]      thr_q;
	logic             disc_en_q;
	logic [IDX_W-1:0] ptr_q;
	logic [CNT_W-1:0] remain_q;
	logic [SUM_W-1:0] sum_q;
	logic [39:0]      hit_ts_q;
	logic [15:0]      res_wait_q;
	logic             res_drop_q;
	swrl_out_t        out_q;

	logic              full;
	logic [IDX_W-1:0]  newest;
	logic [IDX_W-1:0]  wr_slot;
	logic [IDX_W-1:0]  rd_addr;
	logic [SUM_W-1:0]  sum_next;
	logic signed [41:0] wait_diff;
	logic [15:0]       wait_clamped;

	assign full    = (count_q == DEPTH_C);
	assign newest  = idx_add(oldest_q, count_q - 1'b1);
	assign wr_slot = full ? oldest_q : idx_add(oldest_q, count_q);

	always_comb begin
		unique case (cmd.rd_sel)
			RD_OLDEST:      rd_addr = oldest_q;
			RD_OLDEST_NEXT: rd_addr = idx_inc(oldest_q);
			RD_NEWEST:      rd_addr = newest;
			RD_PTR_PREV:    rd_addr = idx_dec(ptr_q);
			default:        rd_addr = oldest_q;
		endcase
	end

	assign sum_next = sum_q + SUM_W'(rdata_q.amount);

	// wait = hit time + window - now, clamped to [0, WAIT_MAX]
	assign wait_diff = $signed({2'b00, hit_ts_q}) + $signed({26'd0, window_q})
	                 - $signed({2'b00, now_q});

	always_comb begin
		if (wait_diff <= 42'sd0)
			wait_clamped = '0;
		else if (wait_diff > 42'sd65535)
			wait_clamped = WAIT_MAX;
		else
			wait_clamped = wait_diff[15:0];
	end

	assign st.mode      = limit_mode_q;
	assign st.disc_en   = disc_en_q;
	assign st.count_nz  = (count_q != '0);
	assign st.count_gt1 = (count_q > CNT_W'(1));
	assign st.old       = (rdata_q.ts_ms < thr_q);
	assign st.reached   = (CMP_W'(sum_next) >= CMP_W'(limit_bytes_q));
	assign st.last      = (remain_q == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_mode_q  <= '0;
			limit_bytes_q <= '0;
			history_q     <= HISTORY_RST;
			window_q      <= WINDOW_RST;
			blocked_q     <= BLOCKED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LIMIT_MODE:   limit_mode_q  <= cfg_data[1:0];
				CFG_LIMIT_BYTES:  limit_bytes_q <= cfg_data;
				CFG_HISTORY_MS:   history_q     <= cfg_data[15:0];
				CFG_WINDOW_MS:    window_q      <= cfg_data[15:0];
				CFG_BLOCKED_WAIT: blocked_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q  <= '0;
		end else if (cmd.record) begin
			if (full)
				oldest_q <= idx_inc(oldest_q);
			else
				count_q <= count_q + 1'b1;
		end else if (cmd.pop) begin
			oldest_q <= idx_inc(oldest_q);
			count_q  <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.record)
			ring_mem[wr_slot] <= '{ts_ms: now_q, amount: amount_in_q};
		if (cmd.rd_en)
			rdata_q <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			now_q       <= in_data.now_ms;
			amount_in_q <= in_data.amount;
			disc_en_q   <= (in_data.now_ms >= {24'd0, history_q});
			thr_q       <= in_data.now_ms - {24'd0, history_q};
		end
		if (cmd.sum_start) begin
			sum_q    <= '0;
			ptr_q    <= newest;
			remain_q <= count_q;
		end else begin
			if (cmd.acc)
				sum_q <= sum_next;
			if (cmd.step) begin
				ptr_q    <= idx_dec(ptr_q);
				remain_q <= remain_q - 1'b1;
			end
		end
		if (cmd.hit)
			hit_ts_q <= rdata_q.ts_ms;
		if (cmd.record) begin
			res_wait_q <= '0;
			res_drop_q <= full;
		end else begin
			unique case (cmd.res_op)
				RES_ZERO: begin
					res_wait_q <= '0;
					res_drop_q <= 1'b0;
				end
				RES_BLOCKED: begin
					res_wait_q <= blocked_q;
					res_drop_q <= 1'b0;
				end
				RES_WINDOW: begin
					res_wait_q <= wait_clamped;
					res_drop_q <= 1'b0;
				end
				RES_HOLD: ;
				default: ;
			endcase
		end
		if (cmd.load_out)
			out_q <= '{wait_ms: res_wait_q, dropped_oldest: res_drop_q};
	end

	assign out_data = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above ring depth");

	a_oldest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oldest_q <= LAST_IDX)
		else $error("oldest index outside ring");

	a_full_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.record && full) |=> (count_q == DEPTH_C))
		else $error("record into full ring changed entry count");

endmodule

// ===== hw/rtl/swrl_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences record, discard, backward sum and result hand-off.
module swrl_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_func,
	output logic                   in_stall,
	output logic                   out_valid,
	input  logic                   out_stall,
	input  swrl_pkg::swrl_status_t st,
	output swrl_pkg::swrl_cmd_t    cmd
);
	import swrl_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REC,
		ST_QRY,
		ST_DISC,
		ST_SEL,
		ST_SUM,
		ST_FIN,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = in_func ? ST_QRY : ST_REC;
				end
			end
			ST_REC: begin
				cmd.record = 1'b1;
				state_d    = ST_DONE;
			end
			ST_QRY: begin
				if (st.disc_en && st.count_nz) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_OLDEST;
					state_d    = ST_DISC;
				end else begin
					state_d = ST_SEL;
				end
			end
			ST_DISC: begin
				// drop stale entries from the oldest end, prefetching the next one
				if (st.old) begin
					cmd.pop = 1'b1;
					if (st.count_gt1) begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_OLDEST_NEXT;
					end else begin
						state_d = ST_SEL;
					end
				end else begin
					state_d = ST_SEL;
				end
			end
			ST_SEL: begin
				if (st.mode == MODE_BLOCKED) begin
					cmd.res_op = RES_BLOCKED;
					state_d    = ST_DONE;
				end else if (st.mode == MODE_BYTES && st.count_nz) begin
					cmd.sum_start = 1'b1;
					cmd.rd_en     = 1'b1;
					cmd.rd_sel    = RD_NEWEST;
					state_d       = ST_SUM;
				end else begin
					cmd.res_op = RES_ZERO;
					state_d    = ST_DONE;
				end
			end
			ST_SUM: begin
				cmd.acc = 1'b1;
				if (st.reached) begin
					cmd.hit = 1'b1;
					state_d = ST_FIN;
				end else if (st.last) begin
					cmd.res_op = RES_ZERO;
					state_d    = ST_DONE;
				end else begin
					cmd.step   = 1'b1;
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PTR_PREV;
				end
			end
			ST_FIN: begin
				cmd.res_op = RES_WINDOW;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second transaction accepted while one is in work");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a stalled result");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> st.count_nz)
		else $error("discard from empty ring");

endmodule

// ===== verif/tb_sliding_window_rate_limiter_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sliding-window rate limiter: directed cases, then random phases.
module tb_sliding_window_rate_limiter_unit;
	import swrl_pkg::*;

	localparam int RING_DEPTH = 256;

	localparam logic FUNC_RECORD = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	localparam logic [1:0] MODE_OPEN  = 2'd0;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	localparam logic [39:0] STAMP_MAX = 40'hFF_FFFF_FFFF;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	swrl_in_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	swrl_out_t             out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predictor state: ring contents and a shadow of the registers
	logic [39:0] ring_stamp [RING_DEPTH];
	logic [23:0] ring_bytes [RING_DEPTH];
	int unsigned head_slot = 0;
	int unsigned fill_count = 0;
	logic [1:0]  mode_reg = MODE_OPEN;
	logic [31:0] byte_limit_reg = '0;
	logic [15:0] history_reg = HISTORY_RST;
	logic [15:0] window_reg = WINDOW_RST;
	logic [15:0] blocked_reg = BLOCKED_RST;

	swrl_in_t    queued_transfers [$];
	swrl_out_t   owed_responses [$];
	logic        in_taken = 1'b0;
	int unsigned tx_gap_pct = 0;
	int unsigned rx_stall_pct = 0;
	int unsigned fault_count = 0;
	logic [39:0] stamp_ms = '0;

	sliding_window_rate_limiter_unit #(
		.RING_DEPTH(RING_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic swrl_out_t limiter_response(swrl_in_t item);
		swrl_out_t       resp;
		int unsigned     slot;
		int unsigned     k;
		longint unsigned total;
		longint          remain;
		logic [39:0]     cutoff;
		bit              reached;
		resp = '0;
		if (item.func == FUNC_RECORD) begin
			if (fill_count >= RING_DEPTH) begin
				slot = head_slot;
				head_slot = (head_slot + 1) % RING_DEPTH;
				resp.dropped_oldest = 1'b1;
			end else begin
				slot = (head_slot + fill_count) % RING_DEPTH;
				fill_count++;
			end
			ring_stamp[slot] = item.now_ms;
			ring_bytes[slot] = item.amount;
			return resp;
		end
		// drop stale entries from the oldest end, stop at the first fresh one
		if (item.now_ms >= {24'd0, history_reg}) begin
			cutoff = item.now_ms - {24'd0, history_reg};
			while (fill_count > 0 && ring_stamp[head_slot] < cutoff) begin
				head_slot = (head_slot + 1) % RING_DEPTH;
				fill_count--;
			end
		end
		if (mode_reg == MODE_BLOCKED)
			resp.wait_ms = blocked_reg;
		else if (mode_reg == MODE_BYTES) begin
			total = 0;
			reached = 1'b0;
			k = fill_count;
			while (k > 0 && !reached) begin
				slot = (head_slot + k - 1) % RING_DEPTH;
				total += 64'(ring_bytes[slot]);
				if (total >= 64'(byte_limit_reg)) begin
					reached = 1'b1;
					remain = longint'({24'd0, ring_stamp[slot]}) + longint'({48'd0, window_reg})
						- longint'({24'd0, item.now_ms});
					if (remain > 65535)
						resp.wait_ms = WAIT_MAX;
					else if (remain > 0)
						resp.wait_ms = remain[15:0];
				end
				k--;
			end
		end
		return resp;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_LIMIT_MODE:   mode_reg = value[1:0];
			CFG_LIMIT_BYTES:  byte_limit_reg = value;
			CFG_HISTORY_MS:   history_reg = value[15:0];
			CFG_WINDOW_MS:    window_reg = value[15:0];
			CFG_BLOCKED_WAIT: blocked_reg = value[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_item(logic func, logic [39:0] now, logic [23:0] amount);
		swrl_in_t item;
		item.func = func;
		item.now_ms = now;
		item.amount = amount;
		queued_transfers = {queued_transfers, item};
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (queued_transfers.size() != 0 || in_valid || owed_responses.size() != 0);
		repeat (2) @(negedge clk);
	endtask

	task automatic randomize_config();
		int unsigned pick;
		logic [1:0]  mode;
		logic [31:0] limit;
		logic [15:0] history;
		logic [15:0] window;
		pick = $urandom_range(9);
		if (pick == 6)
			mode = MODE_OPEN;
		else if (pick == 7)
			mode = MODE_BLOCKED;
		else if (pick == 8)
			mode = MODE_SPARE;
		else
			mode = MODE_BYTES;
		pick = $urandom_range(9);
		if (pick < 3)
			limit = $urandom_range(1 << 25);
		else if (pick < 6)
			limit = $urandom_range(20000);
		else if (pick == 6)
			limit = '0;
		else if (pick == 7)
			limit = '1;
		else
			limit = $urandom();
		pick = $urandom_range(9);
		if (pick < 6)
			history = 16'($urandom_range(8000, 100));
		else if (pick == 6)
			history = '0;
		else if (pick == 7)
			history = '1;
		else
			history = 16'($urandom());
		pick = $urandom_range(9);
		if (pick < 6)
			window = 16'($urandom_range(3000, 1));
		else if (pick == 6)
			window = '0;
		else if (pick == 7)
			window = '1;
		else
			window = 16'($urandom());
		write_reg(CFG_LIMIT_MODE, {30'd0, mode});
		write_reg(CFG_LIMIT_BYTES, limit);
		write_reg(CFG_HISTORY_MS, {16'd0, history});
		write_reg(CFG_WINDOW_MS, {16'd0, window});
		write_reg(CFG_BLOCKED_WAIT, $urandom_range(65535));
	endtask

	// calm keeps time moving forward in small steps so the ring can fill up
	task automatic add_random_items(int unsigned count, int unsigned record_pct, bit calm);
		int unsigned pick;
		logic [23:0] amount;
		logic        func;
		repeat (count) begin
			pick = $urandom_range(99);
			if (calm || pick < 70)
				stamp_ms += 40'($urandom_range(20));
			else if (pick < 85)
				stamp_ms += 40'($urandom_range(3000));
			else if (pick < 92)
				stamp_ms = (stamp_ms > 40'd2000) ? stamp_ms - 40'($urandom_range(2000)) : '0;
			else if (pick < 96)
				stamp_ms = {8'($urandom()), 32'($urandom())};
			else if (pick < 98)
				stamp_ms = STAMP_MAX - 40'($urandom_range(5000));
			else
				stamp_ms = 40'($urandom_range(6000));
			pick = $urandom_range(9);
			if (pick < 4)
				amount = 24'($urandom());
			else if (pick < 8)
				amount = 24'($urandom_range(4095));
			else if (pick == 8)
				amount = '0;
			else
				amount = '1;
			func = ($urandom_range(99) < record_pct) ? FUNC_RECORD : FUNC_QUERY;
			push_item(func, stamp_ms, amount);
		end
	endtask

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (queued_transfers.size() != 0 && $urandom_range(99) >= tx_gap_pct) begin
				in_valid <= 1'b1;
				in_data <= queued_transfers.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < rx_stall_pct);
	end

	always @(posedge clk) begin
		swrl_out_t want;
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			owed_responses = {owed_responses, limiter_response(in_data)};
		if (arst_n && out_valid && !out_stall) begin
			if (owed_responses.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected result: wait_ms=%0d dropped_oldest=%0b",
						out_data.wait_ms, out_data.dropped_oldest);
			end else begin
				want = owed_responses.pop_front();
				if (out_data.wait_ms !== want.wait_ms
						|| out_data.dropped_oldest !== want.dropped_oldest) begin
					fault_count++;
					if (fault_count <= 10)
						$display("mismatch: expected wait_ms=%0d dropped_oldest=%0b, got wait_ms=%0d dropped_oldest=%0b",
							want.wait_ms, want.dropped_oldest,
							out_data.wait_ms, out_data.dropped_oldest);
				end
			end
		end
	end

	initial begin
		#30_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int unsigned phase;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty ring, reset defaults, early time
		push_item(FUNC_QUERY, 40'd0, 24'd0);
		push_item(FUNC_RECORD, 40'd0, 24'hFF_FFFF);
		push_item(FUNC_RECORD, 40'd0, 24'd0);
		push_item(FUNC_QUERY, 40'd10, 24'hFF_FFFF);
		wait_idle();
		write_reg(CFG_LIMIT_MODE, {30'd0, MODE_SPARE});
		push_item(FUNC_QUERY, 40'd20, 24'd0);
		wait_idle();
		// blocked mode; writes to unused indexes change nothing
		write_reg(CFG_LIMIT_MODE, {30'd0, MODE_BLOCKED});
		write_reg(CFG_BLOCKED_WAIT, 32'h0000_FFFF);
		write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
		write_reg(CFG_SPARE_HI, 32'h0000_0000);
		push_item(FUNC_QUERY, 40'd30, 24'd0);
		wait_idle();
		// zero byte limit answers from the newest entry
		write_reg(CFG_BLOCKED_WAIT, 32'd0);
		write_reg(CFG_LIMIT_MODE, {30'd0, MODE_BYTES});
		write_reg(CFG_LIMIT_BYTES, 32'd0);
		push_item(FUNC_QUERY, 40'd40, 24'd0);
		push_item(FUNC_QUERY, 40'd2000, 24'd0);
		wait_idle();
		// record ahead of the query time: wait saturates
		write_reg(CFG_WINDOW_MS, 32'h0000_FFFF);
		write_reg(CFG_LIMIT_BYTES, 32'd1);
		push_item(FUNC_RECORD, 40'd200000, 24'd1);
		push_item(FUNC_QUERY, 40'd150000, 24'd0);
		push_item(FUNC_RECORD, 40'd100, 24'd5);
		wait_idle();
		// older entry behind a fresh oldest one survives; limit never reached
		write_reg(CFG_LIMIT_BYTES, 32'hFFFF_FFFF);
		push_item(FUNC_QUERY, 40'd201000, 24'd0);
		wait_idle();
		write_reg(CFG_HISTORY_MS, 32'd0);
		write_reg(CFG_WINDOW_MS, 32'd0);
		write_reg(CFG_LIMIT_BYTES, 32'd0);
		push_item(FUNC_QUERY, STAMP_MAX, 24'd0);
		push_item(FUNC_RECORD, STAMP_MAX, 24'hFF_FFFF);
		push_item(FUNC_QUERY, STAMP_MAX, 24'd0);
		wait_idle();
		write_reg(CFG_HISTORY_MS, 32'h0000_FFFF);
		write_reg(CFG_WINDOW_MS, {16'd0, WINDOW_RST});
		push_item(FUNC_QUERY, 40'd3, 24'd0);
		wait_idle();

		stamp_ms = 40'd1000;
		for (phase = 0; phase < 8; phase++) begin
			randomize_config();
			case (phase % 4)
				0: begin
					tx_gap_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_gap_pct = 49;
					rx_stall_pct = 0;
				end
				2: begin
					tx_gap_pct = 0;
					rx_stall_pct = 49;
				end
				default: begin
					tx_gap_pct = 9;
					rx_stall_pct = 9;
				end
			endcase
			if (phase == 2) begin
				// mostly records with a long history: overflow the ring
				write_reg(CFG_HISTORY_MS, 32'h0000_FFFF);
				add_random_items(300, 95, 1'b1);
			end else begin
				add_random_items(64, 60, 1'b0);
			end
			wait_idle();
		end

		repeat (600) @(posedge clk);
		if (owed_responses.size() != 0)
			fault_count++;
		if (fault_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
